// ===== rtl/hte_pkg.sv =====
// Shared types and constants for the Huffman tree byte expander.
`default_nettype none
package hte_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0]  HEAD_NODE  = 8'd254;
    localparam logic [15:0] MAX_LENGTH = 16'd65000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CHILD = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DATA  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_START   = 2'd1,
        KIND_BAD_LEN = 2'd2,
        KIND_DATA    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WALK  = 2'd1,
        S_FLUSH = 2'd2
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  node_index;
        logic [15:0] child_zero;
        logic [15:0] child_one;
        logic [7:0]  data_byte;
        logic [15:0] out_length;
    } t_cmd;

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic [1:0] status;
        logic       lump_done;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/hte_front.sv =====
// Front end: takes input transfers, classifies them and pushes commands.
`default_nettype none
module hte_front
    import hte_pkg::*;
(
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_node_index,
    input  wire logic [15:0] i_child_zero,
    input  wire logic [15:0] i_child_one,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_out_length,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_cmd             o_q_cmd
);

    logic known;

    always_comb begin
        o_q_cmd.node_index = i_node_index;
        o_q_cmd.child_zero = i_child_zero;
        o_q_cmd.child_one  = i_child_one;
        o_q_cmd.data_byte  = i_data_byte;
        o_q_cmd.out_length = i_out_length;
        o_q_cmd.kind       = KIND_LOAD;
        known              = 1'b1;
        unique case (i_op)
            OP_LOAD: begin
                o_q_cmd.kind = KIND_LOAD;
            end
            OP_START: begin
                if ((i_out_length == 16'd0) || (i_out_length > MAX_LENGTH)) begin
                    o_q_cmd.kind = KIND_BAD_LEN;
                end else begin
                    o_q_cmd.kind = KIND_START;
                end
            end
            OP_DATA: begin
                o_q_cmd.kind = KIND_DATA;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && known;

endmodule
`default_nettype wire

// ===== rtl/hte_queue.sv =====
// Short command queue between the front end and the tree walker.
`default_nettype none
module hte_queue
    import hte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
    end

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hte_back.sv =====
// Back end: node table, bit-serial tree walk and the result register.
`default_nettype none
module hte_back
    import hte_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_result   o_result,
    output logic      o_last
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [31:0] r_mem [NODE_COUNT];

    t_state      r_state;
    t_state      n_state;
    logic [7:0]  r_node;
    logic [7:0]  n_node;
    logic [15:0] r_rem;
    logic        r_active;
    logic [7:0]  r_byte;
    logic [2:0]  r_bit;
    logic [31:0] r_rd;
    t_result     r_pend;
    logic        r_pend_v;
    t_result     r_out;
    logic        r_out_last;
    logic        r_out_v;

    logic [15:0] child;
    logic        is_lit;
    logic        is_ptr;
    logic        has_res;
    logic        done_lit;
    logic        out_free;
    logic        walk_stall;
    logic        walk_end;
    t_result     new_res;

    logic        pop;
    logic        do_load;
    logic        do_start;
    logic        do_bad;
    logic        do_data;
    logic        walk_step;
    logic        out_from_pend;

    always_comb begin
        child    = r_byte[r_bit] ? r_rd[31:16] : r_rd[15:0];
        is_lit   = (child[15:8] == 8'd0);
        is_ptr   = !is_lit && (child[15:9] == 7'd0);
        has_res  = !is_ptr;
        done_lit = is_lit && (r_rem == 16'd1);
        out_free = !r_out_v || i_out_ready;
        walk_stall = has_res && r_pend_v && !out_free;
        walk_end   = !walk_stall && (done_lit || (r_bit == 3'd7));
        new_res.symbol       = is_lit ? child[7:0] : 8'd0;
        new_res.symbol_valid = is_lit;
        new_res.status       = is_lit ? ST_OK : ST_BAD_CHILD;
        new_res.lump_done    = done_lit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop && (i_q_cmd.kind == KIND_DATA) && r_active) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        pop           = 1'b0;
        walk_step     = 1'b0;
        out_from_pend = 1'b0;
        n_node        = r_node;
        unique case (r_state)
            S_IDLE: begin
                pop = i_q_valid && ((i_q_cmd.kind != KIND_BAD_LEN) || out_free);
                if (pop && (i_q_cmd.kind == KIND_START)) begin
                    n_node = HEAD_NODE;
                end
            end
            S_WALK: begin
                walk_step     = !walk_stall;
                out_from_pend = walk_step && has_res && r_pend_v;
                if (walk_step && is_lit) begin
                    n_node = HEAD_NODE;
                end else if (walk_step && is_ptr) begin
                    n_node = child[7:0];
                end
            end
            S_FLUSH: begin
                out_from_pend = r_pend_v && out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
        do_load  = pop && (i_q_cmd.kind == KIND_LOAD);
        do_start = pop && (i_q_cmd.kind == KIND_START);
        do_bad   = pop && (i_q_cmd.kind == KIND_BAD_LEN);
        do_data  = pop && (i_q_cmd.kind == KIND_DATA);
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[i_q_cmd.node_index[AW-1:0]] <= {i_q_cmd.child_one, i_q_cmd.child_zero};
        end
        r_rd <= r_mem[n_node[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (do_data) begin
            r_byte <= i_q_cmd.data_byte;
            r_bit  <= 3'd0;
        end else if (walk_step) begin
            r_bit <= r_bit + 3'd1;
        end
        if (walk_step && has_res) begin
            r_pend <= new_res;
        end
        if (out_from_pend) begin
            r_out      <= r_pend;
            r_out_last <= (r_state == S_FLUSH);
        end else if (do_bad) begin
            r_out.symbol       <= 8'd0;
            r_out.symbol_valid <= 1'b0;
            r_out.status       <= ST_BAD_LEN;
            r_out.lump_done    <= 1'b0;
            r_out_last         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_node   <= HEAD_NODE;
            r_rem    <= 16'd0;
            r_active <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            if (do_start) begin
                r_rem    <= i_q_cmd.out_length;
                r_active <= 1'b1;
            end else if (do_bad) begin
                r_active <= 1'b0;
            end else if (walk_step && is_lit) begin
                r_rem <= r_rem - 16'd1;
                if (done_lit) begin
                    r_active <= 1'b0;
                end
            end
            if (walk_step && has_res) begin
                r_pend_v <= 1'b1;
            end else if (out_from_pend) begin
                r_pend_v <= 1'b0;
            end
            if (out_from_pend || do_bad) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/huffman_tree_byte_expander_unit.sv =====
// Huffman tree byte expander: accepts table loads, lump starts and data bytes, emits decoded bytes.
// Input channel (i_in_valid / o_in_ready): op 0 loads one node of the 256-node tree table,
// op 1 starts a lump with an expanded length, op 2 carries one compressed byte, op 3 is dropped.
// Output channel (o_out_valid / i_out_ready): one transfer per literal or per bad child met,
// plus one transfer with status 2 for a rejected length; o_last marks the final result of an input.
// A two-entry command queue sits between the front end and the tree walker, so input transfers
// keep flowing while the walker works or the receiver stalls.
// A data byte is dequeued in the idle state, then walked in the walk state one bit per cycle
// (up to 8) unless the output stalls, bounded by the single node read per cycle from the table
// memory, and ends in the flush state, which releases the held result; loads and starts are
// taken in the idle state. A rejected length passes through the queue into the output register;
// each result of a byte is held in a pending register until the next one or the end of the byte.
// The output register holds a result until taken; when it and the pending register are both full,
// the walker stalls on the next result and the queue fills, after which o_in_ready drops.
// Reset (i_rst_n low, synchronous) empties the queue and output, parks the walk on head node 254
// and clears the lump; the node table is not cleared and must be loaded before use.
`default_nettype none
module huffman_tree_byte_expander_unit
    import hte_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_node_index,
    input  wire logic [15:0] i_child_zero,
    input  wire logic [15:0] i_child_one,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_out_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_symbol,
    output logic             o_symbol_valid,
    output logic [1:0]       o_status,
    output logic             o_lump_done,
    output logic             o_last
);

    logic    q_full;
    logic    q_push;
    t_cmd    q_in_cmd;
    logic    q_pop;
    logic    q_valid;
    t_cmd    q_out_cmd;
    t_result result;

    hte_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_node_index (i_node_index),
        .i_child_zero (i_child_zero),
        .i_child_one  (i_child_one),
        .i_data_byte  (i_data_byte),
        .i_out_length (i_out_length),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    hte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    hte_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result),
        .o_last      (o_last)
    );

    assign o_symbol       = result.symbol;
    assign o_symbol_valid = result.symbol_valid;
    assign o_status       = result.status;
    assign o_lump_done    = result.lump_done;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the Huffman tree byte expander: directed table, random lumps, scoreboard.
`timescale 1ns / 1ps
module testbench;
    import hte_pkg::*;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [15:0] LITERAL_LIMIT = 16'd256;
    localparam logic [15:0] POINTER_LIMIT = 16'd512;
    localparam int          TOTAL_ITEMS   = 460;
    localparam int          LONG_HOLD     = 400;
    localparam int          END_DRAIN     = 40;
    localparam int          CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_NONE    = 2'd1,
        ROW_BAD_LEN = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [7:0] symbol;
        logic       sym_valid;
        logic [1:0] status;
        logic       lump_done;
        logic       last;
    } t_symbol_rec;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [15:0] cz;
        logic [15:0] co;
        logic [7:0]  db;
        logic [15:0] len;
        t_row_kind   kind;
    } t_dir_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op           = OP_LOAD;
    logic [7:0]  i_node_index   = 8'd0;
    logic [15:0] i_child_zero   = 16'd0;
    logic [15:0] i_child_one    = 16'd0;
    logic [7:0]  i_data_byte    = 8'd0;
    logic [15:0] i_out_length   = 16'd0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [7:0]  o_symbol;
    logic        o_symbol_valid;
    logic [1:0]  o_status;
    logic        o_lump_done;
    logic        o_last;

    huffman_tree_byte_expander_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_node_index   (i_node_index),
        .i_child_zero   (i_child_zero),
        .i_child_one    (i_child_one),
        .i_data_byte    (i_data_byte),
        .i_out_length   (i_out_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_status       (o_status),
        .o_lump_done    (o_lump_done),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0]  tree_tbl [0:255];
    logic [7:0]   walk_node  = HEAD_NODE;
    logic [15:0]  left_count = 16'd0;
    bit           walking    = 1'b0;
    t_symbol_rec  sym_q [$];
    int           last_pushed;

    t_dir_row     dir_rows [$];
    bit           burst      = 1'b0;
    bit           stall_go   = 1'b0;
    bit           stall_done = 1'b0;
    int           rx_hold    = 0;
    int           rx_free    = 0;
    int           rx_pick;
    int           cycle_cnt  = 0;
    int           errors     = 0;
    int           live_items = 0;
    int           n_loads    = 0;
    int           n_starts   = 0;
    int           n_bytes    = 0;
    int           n_results  = 0;
    t_symbol_rec  want;

    task automatic report_mismatch(input string field, input int got, input int exp_val);
        errors++;
        $display("MISMATCH cycle %0d result %0d: %s got %0d expected %0d",
                 cycle_cnt, n_results, field, got, exp_val);
    endtask

    task automatic expand_item(input logic [1:0] op, input logic [7:0] idx,
                               input logic [15:0] cz, input logic [15:0] co,
                               input logic [7:0] db, input logic [15:0] len,
                               output bit counted);
        t_symbol_rec batch [0:7];
        t_symbol_rec r;
        logic [31:0] node;
        logic [15:0] child;
        int          n;
        int          b;
        bit          stop;
        n = 0;
        stop = 1'b0;
        counted = 1'b1;
        case (op)
            OP_LOAD: begin
                tree_tbl[idx] = {co, cz};
                n_loads++;
            end
            OP_START: begin
                n_starts++;
                if (len == 16'd0 || len > MAX_LENGTH) begin
                    walking = 1'b0;
                    r = '0;
                    r.status = ST_BAD_LEN;
                    batch[0] = r;
                    n = 1;
                end else begin
                    walking = 1'b1;
                    left_count = len;
                    walk_node = HEAD_NODE;
                end
            end
            OP_DATA: begin
                if (!walking) begin
                    counted = 1'b0;
                end else begin
                    n_bytes++;
                    for (b = 0; b < 8 && !stop; b++) begin
                        node = tree_tbl[walk_node];
                        child = db[b] ? node[31:16] : node[15:0];
                        if (child < LITERAL_LIMIT) begin
                            left_count = left_count - 16'd1;
                            r = '0;
                            r.symbol = child[7:0];
                            r.sym_valid = 1'b1;
                            r.status = ST_OK;
                            r.lump_done = (left_count == 16'd0);
                            batch[n] = r;
                            n++;
                            walk_node = HEAD_NODE;
                            if (left_count == 16'd0) begin
                                walking = 1'b0;
                                stop = 1'b1;
                            end
                        end else if (child < POINTER_LIMIT) begin
                            walk_node = child[7:0];
                        end else begin
                            r = '0;
                            r.status = ST_BAD_CHILD;
                            batch[n] = r;
                            n++;
                        end
                    end
                end
            end
            default: counted = 1'b0;
        endcase
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (b = 0; b < n; b++)
            sym_q.push_back(batch[b]);
        last_pushed = n;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_child();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'($urandom_range(0, 255));
        if (r < 85)
            return 16'($urandom_range(256, 511));
        return 16'($urandom_range(512, 65535));
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [7:0] idx,
                            input logic [15:0] cz, input logic [15:0] co,
                            input logic [7:0] db, input logic [15:0] len);
        int gap;
        bit counted;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_node_index <= idx;
        i_child_zero <= cz;
        i_child_one  <= co;
        i_data_byte  <= db;
        i_out_length <= len;
        do @(posedge i_clk); while (!o_in_ready);
        expand_item(op, idx, cz, co, db, len, counted);
        if (counted)
            live_items++;
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [15:0] cz, input logic [15:0] co);
        push_cmd(OP_LOAD, idx, cz, co, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_start(input logic [15:0] len);
        push_cmd(OP_START, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), len);
    endtask

    task automatic send_data(input logic [7:0] db);
        push_cmd(OP_DATA, 8'($urandom), 16'($urandom), 16'($urandom), db, 16'($urandom));
    endtask

    function automatic t_dir_row mk_row(input logic [1:0] op, input logic [7:0] idx,
                                        input logic [15:0] cz, input logic [15:0] co,
                                        input logic [7:0] db, input logic [15:0] len,
                                        input t_row_kind kind);
        t_dir_row row;
        row.op = op;
        row.idx = idx;
        row.cz = cz;
        row.co = co;
        row.db = db;
        row.len = len;
        row.kind = kind;
        return row;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, sym_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sym_q.size() == 0) begin
                report_mismatch("unexpected result, symbol", o_symbol, -1);
            end else begin
                want = sym_q.pop_front();
                if (o_symbol !== want.symbol)
                    report_mismatch("symbol", o_symbol, want.symbol);
                if (o_symbol_valid !== want.sym_valid)
                    report_mismatch("symbol_valid", o_symbol_valid, want.sym_valid);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_lump_done !== want.lump_done)
                    report_mismatch("lump_done", o_lump_done, want.lump_done);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
            n_results++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            rx_hold = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (rx_free > 0) begin
            i_out_ready <= 1'b1;
            rx_free = rx_free - 1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 3) begin
                rx_hold = $urandom_range(8, 30);
                i_out_ready <= 1'b0;
            end else if (rx_pick < 9) begin
                rx_free = $urandom_range(20, 60);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (rx_pick < 75);
            end
        end
    end

    initial begin
        int k;
        int pick;
        int r;
        int nb;
        logic [15:0] len;
        t_symbol_rec bad;

        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'hFF, 16'd0,
                                  ROW_NONE));
        dir_rows.push_back(mk_row(OP_UNUSED, 8'hFF,  16'hFFFF,  16'hFFFF,  8'hFF, 16'hFFFF,
                                  ROW_NONE));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'd0,
                                  ROW_BAD_LEN));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'd65001,
                                  ROW_BAD_LEN));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'hFFFF,
                                  ROW_BAD_LEN));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h00, 16'd0,
                                  ROW_NONE));
        dir_rows.push_back(mk_row(OP_LOAD,   8'd254, 16'd266,   16'd255,   8'd0,  16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_LOAD,   8'd10,  16'd0,     16'd256,   8'd0,  16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_LOAD,   8'd0,   16'd511,   16'd65,    8'd0,  16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_LOAD,   8'd255, 16'hFFFF,  16'd512,   8'd0,  16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  MAX_LENGTH,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'hFF, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h00, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h06, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h01, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'd1,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'hFF, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h55, 16'd0,
                                  ROW_NONE));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'd3,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'h00, 16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_START,  8'd0,   16'd0,     16'd0,     8'd0,  16'd2,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_LOAD,   8'd254, 16'd266,   16'h0080,  8'd0,  16'd0,
                                  ROW_PREDICT));
        dir_rows.push_back(mk_row(OP_DATA,   8'd0,   16'd0,     16'd0,     8'hFF, 16'd0,
                                  ROW_PREDICT));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++) begin
            push_cmd(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].cz, dir_rows[k].co,
                     dir_rows[k].db, dir_rows[k].len);
            if (dir_rows[k].kind != ROW_PREDICT) begin
                repeat (last_pushed) sym_q.pop_back();
                if (dir_rows[k].kind == ROW_BAD_LEN) begin
                    bad = '0;
                    bad.status = ST_BAD_LEN;
                    bad.last = 1'b1;
                    sym_q.push_back(bad);
                end
            end
        end

        // fill every node so no walk can reach an unwritten entry
        for (k = 0; k < 256; k++)
            send_load(8'(k), rand_child(), rand_child());

        stall_go = 1'b1;
        burst = 1'b1;
        while (live_items < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    len = 16'($urandom_range(1, 24));
                else if (r < 97)
                    len = 16'($urandom_range(25, 65000));
                else
                    len = MAX_LENGTH;
                send_start(len);
                nb = 0;
                while (walking && nb < 14) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        send_load(8'($urandom), rand_child(), rand_child());
                    end else if (r < 10) begin
                        push_cmd(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom), 16'($urandom));
                    end else begin
                        send_data(8'($urandom));
                        nb++;
                    end
                end
            end else if (pick < 78) begin
                if ($urandom_range(0, 1) == 0)
                    send_start(16'd0);
                else
                    send_start(16'($urandom_range(65001, 65535)));
            end else if (pick < 86) begin
                send_data(8'($urandom));
                push_cmd(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom), 16'($urandom));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4))
                    send_load(8'($urandom), rand_child(), rand_child());
            end else begin
                send_start(16'($urandom_range(5, 40)));
                repeat ($urandom_range(1, 3)) send_data(8'($urandom));
                send_start(16'($urandom_range(1, 8)));
                nb = 0;
                while (walking && nb < 8) begin
                    send_data(8'($urandom));
                    nb++;
                end
            end
            burst = ($urandom_range(0, 3) == 0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sym_q.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        $display("Summary: %0d table loads, %0d lump starts, %0d data bytes walked",
                 n_loads, n_starts, n_bytes);
        $display("Summary: %0d results checked, %0d mismatches, long receiver hold of %0d cycles",
                 n_results, errors, LONG_HOLD);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
